>>> sv/ifmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_pkg: integer field formatter shared definitions
// Types, codes, microcode program and character helpers for the formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  // Field limits
  localparam int MAX_FIELD_WIDTH = 64;
  localparam int MAX_PRECISION   = 32;

  localparam int VAL_W  = 64;
  localparam int FW_W   = 7;
  localparam int PREC_W = 6;
  localparam int CNT_W  = 7;

  // Digit buffer: 22 nibbles covers 64-bit octal and 20-digit decimal
  localparam int NDIG  = 22;
  localparam int DIG_W = NDIG * 4;
  localparam int ND_W  = $clog2(NDIG + 1);

  // Double dabble, two bits per step
  localparam int BIT_STEPS = VAL_W / 2;
  localparam int BCNT_W    = $clog2(BIT_STEPS);

  localparam int PC_W = 4;

  // Input codes
  localparam logic [1:0] SZ_8      = 2'd0;
  localparam logic [1:0] SZ_16     = 2'd1;
  localparam logic [1:0] SZ_32     = 2'd2;
  localparam logic [1:0] SZ_64     = 2'd3;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // ASCII
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_NOP,
    OP_DABBLE,
    OP_NORM,
    OP_SIZE,
    OP_LD_PADL,
    OP_LD_SIGN,
    OP_LD_ZERO,
    OP_LD_DIG,
    OP_LD_PADR,
    OP_EMIT_SPACE,
    OP_EMIT_SIGN,
    OP_EMIT_ZERO,
    OP_EMIT_DIGIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_HEXOCT,
    C_BITS_LEFT,
    C_NORM_MORE,
    C_CNT_NZ
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic hexoct;
    logic bits_left;
    logic norm_more;
    logic cnt_nz;
  } ifmt_stat_t;

  // Microcode program; a true condition jumps to target, else falls through
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_ACCEPT,     C_NO_IN,     4'd0};
      4'd1:    w = '{OP_NOP,        C_HEXOCT,    4'd3};
      4'd2:    w = '{OP_DABBLE,     C_BITS_LEFT, 4'd2};
      4'd3:    w = '{OP_NORM,       C_NORM_MORE, 4'd3};
      4'd4:    w = '{OP_SIZE,       C_NEVER,     4'd0};
      4'd5:    w = '{OP_LD_PADL,    C_NEVER,     4'd0};
      4'd6:    w = '{OP_EMIT_SPACE, C_CNT_NZ,    4'd6};
      4'd7:    w = '{OP_LD_SIGN,    C_NEVER,     4'd0};
      4'd8:    w = '{OP_EMIT_SIGN,  C_CNT_NZ,    4'd8};
      4'd9:    w = '{OP_LD_ZERO,    C_NEVER,     4'd0};
      4'd10:   w = '{OP_EMIT_ZERO,  C_CNT_NZ,    4'd10};
      4'd11:   w = '{OP_LD_DIG,     C_NEVER,     4'd0};
      4'd12:   w = '{OP_EMIT_DIGIT, C_CNT_NZ,    4'd12};
      4'd13:   w = '{OP_LD_PADR,    C_NEVER,     4'd0};
      4'd14:   w = '{OP_EMIT_SPACE, C_CNT_NZ,    4'd14};
      4'd15:   w = '{OP_NOP,        C_ALWAYS,    4'd0};
      default: w = '{OP_NOP,        C_ALWAYS,    4'd0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (up ? CH_UP_A : CH_LOW_A) + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> sv/ifmt_useq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_useq: microcode sequencer
// Step counter over the program ROM with conditional jumps.
// ----------------------------------------------------------------------------
module ifmt_useq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ifmt_pkg::ifmt_stat_t stat_i,
  output ifmt_pkg::op_e      op_o
);
  import ifmt_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw   = ucode_rom(pc_q);
  assign op_o = uw.op;

  always_comb begin
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !in_valid_i;
      C_HEXOCT:    take = stat_i.hexoct;
      C_BITS_LEFT: take = stat_i.bits_left;
      C_NORM_MORE: take = stat_i.norm_more;
      C_CNT_NZ:    take = stat_i.cnt_nz;
      default:     take = 1'b1;
    endcase
  end

  assign pc_d = take ? uw.target : pc_q + PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/ifmt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_dp: formatter datapath
// Operand capture, digit conversion, field sizing and output word register.
// ----------------------------------------------------------------------------
module ifmt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ifmt_pkg::op_e        op_i,
  output ifmt_pkg::ifmt_stat_t stat_o,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [63:0]          value_i,
  input  logic                 is_signed_i,
  input  logic [1:0]           size_select_i,
  input  logic [1:0]           radix_select_i,
  input  logic                 upper_case_i,
  input  logic                 left_justify_i,
  input  logic                 show_sign_i,
  input  logic                 space_sign_i,
  input  logic                 zero_pad_i,
  input  logic [6:0]           field_width_i,
  input  logic [5:0]           precision_i,
  input  logic                 precision_given_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           char_code_o,
  output logic                 last_char_o
);
  import ifmt_pkg::*;

  // Operand and option registers
  logic [VAL_W-1:0]  mag_q;
  logic [DIG_W-1:0]  dig_q;
  logic [ND_W-1:0]   nd_q;
  logic [BCNT_W-1:0] bcnt_q;
  logic              hexoct_q, upper_q, left_q, zpad_q, has_sign_q;
  logic [7:0]        sign_ch_q;
  logic [PREC_W-1:0] prec_q, zeros_q;
  logic [FW_W-1:0]   fw_q, pad_q;
  logic [CNT_W-1:0]  cnt_q, remain_q;

  // Output word register
  logic              out_valid_q;
  logic [7:0]        char_q;
  logic              last_q;

  // Capture-side values
  logic [VAL_W-1:0]  mask_w, vm_w, mag_w;
  logic              top_w, neg_w;
  logic [DIG_W-1:0]  ld_dig_w;
  logic [VAL_W+1:0]  oct_w;

  // Step values
  logic [DIG_W-1:0]  dab_dig_w;
  logic [VAL_W-1:0]  dab_mag_w;
  logic [PREC_W-1:0] zeros_w;
  logic [FW_W-1:0]   content_w, pad_w, total_w;

  logic accept, is_emit, emit, out_free, norm_more;
  logic [7:0] emit_ch;

  assign in_stall_o = (op_i != OP_ACCEPT);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (size_select_i)
      SZ_8:    begin mask_w = 64'h0000_0000_0000_00FF; top_w = value_i[7];  end
      SZ_16:   begin mask_w = 64'h0000_0000_0000_FFFF; top_w = value_i[15]; end
      SZ_32:   begin mask_w = 64'h0000_0000_FFFF_FFFF; top_w = value_i[31]; end
      SZ_64:   begin mask_w = '1;                      top_w = value_i[63]; end
      default: begin mask_w = '1;                      top_w = value_i[63]; end
    endcase
    vm_w  = value_i & mask_w;
    neg_w = is_signed_i && top_w;
    // the most negative value negates onto itself, which is its magnitude
    mag_w = neg_w ? ((~vm_w + 64'd1) & mask_w) : vm_w;
  end

  // Hex and octal are plain regroupings of the magnitude bits
  always_comb begin
    ld_dig_w = '0;
    oct_w    = {2'b00, mag_w};
    if (radix_select_i == RADIX_HEX) begin
      ld_dig_w[VAL_W-1:0] = mag_w;
    end else if (radix_select_i == RADIX_OCT) begin
      for (int k = 0; k < NDIG; k++) begin
        ld_dig_w[4*k +: 4] = {1'b0, oct_w[3*k +: 3]};
      end
    end
  end

  // Double dabble, two bits per step
  always_comb begin
    dab_dig_w = dig_q;
    dab_mag_w = mag_q;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < NDIG; k++) begin
        if (dab_dig_w[4*k +: 4] >= 4'd5) begin
          dab_dig_w[4*k +: 4] = dab_dig_w[4*k +: 4] + 4'd3;
        end
      end
      dab_dig_w = {dab_dig_w[DIG_W-2:0], dab_mag_w[VAL_W-1]};
      dab_mag_w = {dab_mag_w[VAL_W-2:0], 1'b0};
    end
  end

  assign norm_more = (nd_q != '0) && (dig_q[DIG_W-1 -: 4] == 4'd0);

  // Field sizing: [pad][sign][zeros][digits], or [sign][zeros][digits][pad] when left-justified
  always_comb begin
    zeros_w   = (prec_q > PREC_W'(nd_q)) ? prec_q - PREC_W'(nd_q) : '0;
    content_w = FW_W'(has_sign_q) + FW_W'(zeros_w) + FW_W'(nd_q);
    pad_w     = (fw_q > content_w) ? fw_q - content_w : '0;
    total_w   = (fw_q > content_w) ? fw_q : content_w;
  end

  always_comb begin
    case (op_i)
      OP_EMIT_SPACE: begin is_emit = 1'b1; emit_ch = CH_SPACE;  end
      OP_EMIT_SIGN:  begin is_emit = 1'b1; emit_ch = sign_ch_q; end
      OP_EMIT_ZERO:  begin is_emit = 1'b1; emit_ch = CH_ZERO;   end
      OP_EMIT_DIGIT: begin
        is_emit = 1'b1;
        emit_ch = digit_char(dig_q[DIG_W-1 -: 4], upper_q);
      end
      default:       begin is_emit = 1'b0; emit_ch = CH_SPACE;  end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = is_emit && (cnt_q != '0) && out_free;

  assign stat_o.hexoct    = hexoct_q;
  assign stat_o.bits_left = (bcnt_q != '0);
  assign stat_o.norm_more = norm_more;
  assign stat_o.cnt_nz    = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q   <= emit_ch;
      last_q   <= (remain_q == CNT_W'(1));
      remain_q <= remain_q - CNT_W'(1);
      cnt_q    <= cnt_q - CNT_W'(1);
      if (op_i == OP_EMIT_DIGIT) begin
        dig_q <= {dig_q[DIG_W-5:0], 4'd0};
      end
    end
    case (op_i)
      OP_ACCEPT: begin
        if (accept) begin
          mag_q      <= mag_w;
          dig_q      <= ld_dig_w;
          nd_q       <= ND_W'(NDIG);
          bcnt_q     <= BCNT_W'(BIT_STEPS - 1);
          hexoct_q   <= (radix_select_i == RADIX_HEX) || (radix_select_i == RADIX_OCT);
          upper_q    <= upper_case_i;
          left_q     <= left_justify_i;
          zpad_q     <= zero_pad_i && !precision_given_i && !left_justify_i;
          has_sign_q <= is_signed_i && (neg_w || show_sign_i || space_sign_i);
          sign_ch_q  <= neg_w ? CH_MINUS : (show_sign_i ? CH_PLUS : CH_SPACE);
          if (!precision_given_i) begin
            prec_q <= PREC_W'(1);
          end else if (precision_i > PREC_W'(MAX_PRECISION)) begin
            prec_q <= PREC_W'(MAX_PRECISION);
          end else begin
            prec_q <= precision_i;
          end
          fw_q <= (field_width_i > FW_W'(MAX_FIELD_WIDTH)) ? FW_W'(MAX_FIELD_WIDTH)
                                                           : field_width_i;
        end
      end
      OP_DABBLE: begin
        dig_q <= dab_dig_w;
        mag_q <= dab_mag_w;
        if (bcnt_q != '0) begin
          bcnt_q <= bcnt_q - BCNT_W'(1);
        end
      end
      OP_NORM: begin
        if (norm_more) begin
          dig_q <= {dig_q[DIG_W-5:0], 4'd0};
          nd_q  <= nd_q - ND_W'(1);
        end
      end
      OP_SIZE: begin
        zeros_q  <= zeros_w;
        pad_q    <= pad_w;
        remain_q <= CNT_W'(total_w);
      end
      OP_LD_PADL: cnt_q <= (!left_q && !zpad_q) ? CNT_W'(pad_q) : '0;
      OP_LD_SIGN: cnt_q <= CNT_W'(has_sign_q);
      OP_LD_ZERO: cnt_q <= (zpad_q ? CNT_W'(pad_q) : '0) + CNT_W'(zeros_q);
      OP_LD_DIG:  cnt_q <= CNT_W'(nd_q);
      OP_LD_PADR: cnt_q <= left_q ? CNT_W'(pad_q) : '0;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule
`default_nettype wire

>>> sv/integer_field_formatter.sv
`default_nettype none
// Pacing: set by the microcode program; the emit loops give one character per cycle
//   while the output is not stalled.
// Reset: rst_ni async active low; sequencer returns to the input step, output
//   word register empties. No clearing pass.
// ----------------------------------------------------------------------------
// integer_field_formatter: printf-style integer to ASCII field
// A microcode sequencer steps a small datapath: capture and magnitude,
// decimal conversion by double dabble, digit count by leading-zero shifting,
// field sizing, then one emit loop per field segment.
// ----------------------------------------------------------------------------
module integer_field_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic        is_signed_i,
  input  logic [1:0]  size_select_i,
  input  logic [1:0]  radix_select_i,
  input  logic        upper_case_i,
  input  logic        left_justify_i,
  input  logic        show_sign_i,
  input  logic        space_sign_i,
  input  logic        zero_pad_i,
  input  logic [6:0]  field_width_i,
  input  logic [5:0]  precision_i,
  input  logic        precision_given_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_code_o,
  output logic        last_char_o
);
  import ifmt_pkg::*;

  op_e        op;      // control word operation of the current step
  ifmt_stat_t stat;    // jump conditions back from the datapath

  // Program counter and ROM; input is taken only at the first step
  ifmt_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .op_o       (op)
  );

  // The output word register decouples the emit loops from the consumer,
  // so a new item can be taken while the last character still waits.
  ifmt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .stat_o            (stat),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .value_i           (value_i),
    .is_signed_i       (is_signed_i),
    .size_select_i     (size_select_i),
    .radix_select_i    (radix_select_i),
    .upper_case_i      (upper_case_i),
    .left_justify_i    (left_justify_i),
    .show_sign_i       (show_sign_i),
    .space_sign_i      (space_sign_i),
    .zero_pad_i        (zero_pad_i),
    .field_width_i     (field_width_i),
    .precision_i       (precision_i),
    .precision_given_i (precision_given_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .char_code_o       (char_code_o),
    .last_char_o       (last_char_o)
  );

endmodule
`default_nettype wire

>>> sv/ifmt_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifmt_chk: port-level checks for the formatter
// Watches the handshakes and the item/character ordering at the ports.
// ----------------------------------------------------------------------------
module ifmt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [63:0] value_i,
  input logic        is_signed_i,
  input logic [1:0]  size_select_i,
  input logic [1:0]  radix_select_i,
  input logic        upper_case_i,
  input logic        left_justify_i,
  input logic        show_sign_i,
  input logic        space_sign_i,
  input logic        zero_pad_i,
  input logic [6:0]  field_width_i,
  input logic [5:0]  precision_i,
  input logic        precision_given_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  char_code_o,
  input logic        last_char_o
);

  // one item at a time: a taken word closes the input side
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item still in work");

  // a fresh character is only produced while an item is in work
  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("character produced with no item in work");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(char_code_o) && $stable(last_char_o))
    else $error("output word changed while stalled");

endmodule

bind integer_field_formatter ifmt_chk u_ifmt_chk (.*);
`default_nettype wire
